// ===== rtl/ascii_command_frame_parser_defines.svh =====
// Assertion macros shared by the frame parser RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASCII_COMMAND_FRAME_PARSER_DEFINES_SVH
`define ASCII_COMMAND_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define ACFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define ACFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/acfp_pkg.sv =====
// Shared types, character codes and the command table of the frame parser.
// No dependencies.
`timescale 1ns / 1ps

package acfp_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] status_t;
  typedef logic [4:0] cmd_id_t;
  typedef logic [2:0] kind_t;
  typedef logic [5:0] digit_t;

  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Configuration register indexes
  localparam cfg_idx_t REG_ADDR_FIRST  = 2'd0;
  localparam cfg_idx_t REG_ADDR_SECOND = 2'd1;

  localparam digit_t ADDR_FIRST_RST  = 6'd48;
  localparam digit_t ADDR_SECOND_RST = 6'd49;

  // Status codes
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_INCOMPL   = 3'd1;
  localparam status_t ST_ADDR_MISS = 3'd2;
  localparam status_t ST_NOT_FOUND = 3'd3;
  localparam status_t ST_BAD_ARG   = 3'd4;

  // Argument kinds
  localparam kind_t KIND_NONE = 3'h1;
  localparam kind_t KIND_NUM  = 3'h2;
  localparam kind_t KIND_ANY  = 3'h4;

  // Character codes
  localparam byte_t CHAR_CR   = 8'h0D;
  localparam byte_t CHAR_0    = 8'h30;
  localparam byte_t CHAR_9    = 8'h39;
  localparam byte_t CHAR_DASH = 8'h2D;
  localparam byte_t CHAR_UP_S = 8'h53;
  localparam byte_t CHAR_LO_S = 8'h73;
  localparam byte_t CHAR_LO_A = 8'h61;
  localparam byte_t CHAR_LO_Z = 8'h7A;
  localparam byte_t CASE_FOLD = 8'd32;

  localparam int TEXT_W = 112;
  typedef logic [TEXT_W-1:0] text_t;

  // Command names, right aligned: first letter in the highest used byte
  function automatic text_t rom_text(input cmd_id_t idx);
    text_t t;
    case (idx)
      5'd0:    t = TEXT_W'("ADDR");
      5'd1:    t = TEXT_W'("B");
      5'd2:    t = TEXT_W'("BAUD");
      5'd3:    t = TEXT_W'("BO");
      5'd4:    t = TEXT_W'("BS");
      5'd5:    t = TEXT_W'("CONF");
      5'd6:    t = TEXT_W'("D");
      5'd7:    t = TEXT_W'("FLASH");
      5'd8:    t = TEXT_W'("INT");
      5'd9:    t = TEXT_W'("O");
      5'd10:   t = TEXT_W'("PT");
      5'd11:   t = TEXT_W'("RST");
      5'd12:   t = TEXT_W'("RST/C");
      5'd13:   t = TEXT_W'("S");
      5'd14:   t = TEXT_W'("WRITE");
      5'd15:   t = TEXT_W'("RESETTOFACTORY");
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic byte_t rom_len(input cmd_id_t idx);
    byte_t n;
    case (idx)
      5'd0, 5'd2, 5'd5:           n = 8'd4;
      5'd1, 5'd6, 5'd9, 5'd13:    n = 8'd1;
      5'd3, 5'd4, 5'd10:          n = 8'd2;
      5'd7, 5'd12, 5'd14:         n = 8'd5;
      5'd8, 5'd11:                n = 8'd3;
      5'd15:                      n = 8'd14;
      default:                    n = 8'd0;
    endcase
    return n;
  endfunction

  function automatic kind_t rom_kind(input cmd_id_t idx);
    kind_t k;
    case (idx)
      5'd6:                       k = KIND_ANY;
      5'd11, 5'd12, 5'd14, 5'd15: k = KIND_NONE;
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd7, 5'd8, 5'd9, 5'd10, 5'd13:
                                  k = KIND_NUM;
      default:                    k = '0;
    endcase
    return k;
  endfunction

  // Letter of a name at a position; meaningful only below the name length
  function automatic byte_t rom_char(input cmd_id_t idx, input logic [5:0] pos);
    text_t t;
    byte_t n;
    n = rom_len(idx);
    t = rom_text(idx) >> {3'b000, (n - 8'd1 - {2'b00, pos}), 3'b000};
    return t[7:0];
  endfunction

  // Argument kind of a command id (ids count from one, zero means none)
  function automatic kind_t cmd_kind(input cmd_id_t id);
    kind_t k;
    if (id == '0) begin
      k = '0;
    end else begin
      k = rom_kind(id - 5'd1);
    end
    return k;
  endfunction

endpackage

// ===== rtl/ascii_command_frame_parser.sv =====
// ASCII command frame parser: top level with parser, argument store and result drain.
// Depends on acfp_pkg and ascii_command_frame_parser_defines.svh.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  in      | sink      | in_valid/in_stall  | in_rx_byte
//  out     | source    | out_valid/out_stall| out_status, out_command_id, out_arg_char,
//          |           |                    | out_arg_valid, out_last
//  cfg     | sink      | cfg_valid/cfg_ready| cfg_index, cfg_wdata
//
// One received byte per cycle outside a drain, each settled in the cycle it is taken.
// A frame end queues one status beat plus one beat per stored argument byte; in_stall
// stays high while they drain from the argument RAM, one per cycle unless stalled.
// The status beat goes straight to the output register when that register is free.
// Reset (synchronous, rst_n low) returns the parser to idle, empties the output
// and loads the address digits '0' and '1'; the argument RAM is not cleared.
// out_stall only holds the output register; input is refused solely during a drain.
`timescale 1ns / 1ps
`include "ascii_command_frame_parser_defines.svh"

module ascii_command_frame_parser #(
  parameter int NUM_COMMANDS = 16,
  parameter int NAME_MAX     = 16,
  parameter int ARG_MAX      = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // received characters
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_rx_byte,
  // results
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             out_status,
  output logic [4:0]             out_command_id,
  output logic [7:0]             out_arg_char,
  output logic                   out_arg_valid,
  output logic                   out_last,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  acfp_pkg::cfg_idx_t     cfg_index,
  input  acfp_pkg::digit_t       cfg_wdata
);

  localparam int AW  = (ARG_MAX > 1) ? $clog2(ARG_MAX) : 1;
  localparam int CW  = $clog2(ARG_MAX + 1);
  localparam int NPW = $clog2(NAME_MAX + 1);
  localparam logic [CW-1:0]           ARG_LIM  = CW'(ARG_MAX);
  localparam logic [NPW-1:0]          NAME_LIM = NPW'(NAME_MAX);
  localparam logic [NUM_COMMANDS-1:0] ALL_CMDS = '1;

  // Frame phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ADDR = 2'd1;
  localparam logic [1:0] PH_NAME = 2'd2;
  localparam logic [1:0] PH_ARG  = 2'd3;

  // Restart watch steps
  localparam logic [1:0] RW_NONE  = 2'd0;
  localparam logic [1:0] RW_START = 2'd1;
  localparam logic [1:0] RW_FIRST = 2'd2;

  // Parser state
  logic [1:0]              phase_r, phase_nxt;
  logic                    addr_cnt_r, addr_cnt_nxt;
  logic [NUM_COMMANDS-1:0] match_r, match_nxt;
  logic [NPW-1:0]          name_pos_r, name_pos_nxt;
  acfp_pkg::cmd_id_t       cur_cmd_r, cur_cmd_nxt;
  logic [CW-1:0]           arg_cnt_r, arg_cnt_nxt;
  logic [1:0]              watch_r, watch_nxt;
  acfp_pkg::digit_t        addr_first_r, addr_second_r;

  // Argument RAM
  acfp_pkg::byte_t         arg_mem [ARG_MAX];
  acfp_pkg::byte_t         rd_data_r;
  logic [AW-1:0]           rd_addr;
  logic                    st_we;

  // Drain sequencer
  logic                    drain_active_r, drain_active_nxt;
  logic                    stat_pend_r, stat_pend_nxt;
  logic [CW-1:0]           drain_idx_r, drain_idx_nxt;
  logic [CW-1:0]           drain_cnt_r, drain_cnt_nxt;
  acfp_pkg::status_t       drain_status_r, drain_status_nxt;
  acfp_pkg::cmd_id_t       drain_cmd_r, drain_cmd_nxt;

  // Output register
  logic                    out_valid_r, out_valid_nxt;
  acfp_pkg::status_t       out_status_r, out_status_nxt;
  acfp_pkg::cmd_id_t       out_cmd_r, out_cmd_nxt;
  acfp_pkg::byte_t         out_char_r, out_char_nxt;
  logic                    out_argv_r, out_argv_nxt;
  logic                    out_last_r, out_last_nxt;

  // Byte decode
  logic                    in_fire;
  logic                    load_ok;
  acfp_pkg::byte_t         rx_fold;
  logic                    is_start, is_term;
  logic                    live_zero;
  acfp_pkg::digit_t        want;
  logic                    fin;
  acfp_pkg::status_t       fin_status;
  logic                    clr;
  logic [1:0]              clr_phase;
  logic                    restart;
  logic                    do_store;

  // Name table compare
  logic [NUM_COMMANDS-1:0] hit;
  acfp_pkg::cmd_id_t       cc;
  logic                    cc_found;

  assign in_fire  = in_valid && !in_stall;
  assign in_stall = drain_active_r;
  assign load_ok  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign is_start = (in_rx_byte == acfp_pkg::CHAR_UP_S) || (in_rx_byte == acfp_pkg::CHAR_LO_S);
  assign is_term  = in_rx_byte inside {[acfp_pkg::CHAR_0:acfp_pkg::CHAR_9], acfp_pkg::CHAR_DASH};
  assign live_zero = (name_pos_r != '0) && (match_r == '0);
  assign want = addr_cnt_r ? addr_second_r : addr_first_r;

  // Fold lower-case name letters
  always_comb begin
    rx_fold = in_rx_byte;
    if (in_rx_byte inside {[acfp_pkg::CHAR_LO_A:acfp_pkg::CHAR_LO_Z]}) begin
      rx_fold = in_rx_byte - acfp_pkg::CASE_FOLD;
    end
  end

  // Compare the folded letter against every live table entry at this position
  always_comb begin
    hit      = '0;
    cc       = '0;
    cc_found = 1'b0;
    if (name_pos_r < NAME_LIM) begin
      for (int i = 0; i < NUM_COMMANDS; i++) begin
        if (((name_pos_r == '0) ? ALL_CMDS[i] : match_r[i]) &&
            ({2'b00, 6'(name_pos_r)} < acfp_pkg::rom_len(5'(i))) &&
            (acfp_pkg::rom_char(5'(i), 6'(name_pos_r)) == rx_fold)) begin
          hit[i] = 1'b1;
          if (!cc_found && (acfp_pkg::rom_len(5'(i)) == 8'(name_pos_r) + 8'd1)) begin
            cc       = 5'(i + 1);
            cc_found = 1'b1;
          end
        end
      end
    end
  end

  // Parse one accepted byte
  always_comb begin
    phase_nxt    = phase_r;
    addr_cnt_nxt = addr_cnt_r;
    match_nxt    = match_r;
    name_pos_nxt = name_pos_r;
    cur_cmd_nxt  = cur_cmd_r;
    arg_cnt_nxt  = arg_cnt_r;
    watch_nxt    = watch_r;
    fin          = 1'b0;
    fin_status   = acfp_pkg::ST_OK;
    clr          = 1'b0;
    clr_phase    = PH_IDLE;
    restart      = 1'b0;
    do_store     = 1'b0;
    if (in_fire) begin
      if (in_rx_byte == acfp_pkg::CHAR_CR) begin
        case (phase_r)
          PH_IDLE: begin
          end
          PH_ADDR: begin
            fin        = 1'b1;
            fin_status = acfp_pkg::ST_INCOMPL;
          end
          PH_NAME: begin
            fin = 1'b1;
            if (cur_cmd_r != '0) begin
              fin_status = acfp_pkg::ST_OK;
            end else begin
              fin_status = live_zero ? acfp_pkg::ST_NOT_FOUND : acfp_pkg::ST_INCOMPL;
            end
          end
          default: begin
            fin        = 1'b1;
            fin_status = acfp_pkg::ST_OK;
          end
        endcase
      end else if (phase_r == PH_IDLE) begin
        if (is_start) begin
          clr       = 1'b1;
          clr_phase = PH_ADDR;
        end
      end else if (phase_r == PH_ADDR) begin
        if (is_start) begin
          clr       = 1'b1;
          clr_phase = PH_ADDR;
        end else if (in_rx_byte != {2'b00, want}) begin
          fin        = 1'b1;
          fin_status = acfp_pkg::ST_ADDR_MISS;
        end else if (!addr_cnt_r) begin
          addr_cnt_nxt = 1'b1;
        end else begin
          clr       = 1'b1;
          clr_phase = PH_NAME;
        end
      end else begin
        // watch for an in-frame restart sequence
        if (is_start) begin
          watch_nxt = RW_START;
        end else if (watch_r == RW_START && in_rx_byte == {2'b00, addr_first_r}) begin
          watch_nxt = RW_FIRST;
        end else if (watch_r == RW_FIRST && in_rx_byte == {2'b00, addr_second_r}) begin
          restart = 1'b1;
        end else begin
          watch_nxt = RW_NONE;
        end

        if (restart) begin
          clr       = 1'b1;
          clr_phase = PH_NAME;
        end else if (phase_r == PH_NAME) begin
          if (is_term) begin
            if (cur_cmd_r == '0) begin
              fin        = 1'b1;
              fin_status = live_zero ? acfp_pkg::ST_NOT_FOUND : acfp_pkg::ST_INCOMPL;
            end else if (acfp_pkg::cmd_kind(cur_cmd_r) == acfp_pkg::KIND_NONE) begin
              fin        = 1'b1;
              fin_status = acfp_pkg::ST_OK;
            end else begin
              phase_nxt = PH_ARG;
              do_store  = 1'b1;
            end
          end else begin
            match_nxt   = hit;
            cur_cmd_nxt = cc;
            if (name_pos_r < NAME_LIM) begin
              name_pos_nxt = name_pos_r + 1'b1;
            end
            if (cc != '0 && acfp_pkg::cmd_kind(cc) == acfp_pkg::KIND_ANY) begin
              phase_nxt = PH_ARG;
            end
          end
        end else begin
          if (acfp_pkg::cmd_kind(cur_cmd_r) == acfp_pkg::KIND_NUM && !is_term) begin
            fin        = 1'b1;
            fin_status = acfp_pkg::ST_BAD_ARG;
          end else begin
            do_store = 1'b1;
          end
        end
      end
    end

    // append an argument byte, drop it once the store is full
    st_we = 1'b0;
    if (do_store && arg_cnt_r < ARG_LIM) begin
      st_we       = 1'b1;
      arg_cnt_nxt = arg_cnt_r + 1'b1;
    end

    // frame end, new start, address match or restart: clear the frame
    if (fin) begin
      clr       = 1'b1;
      clr_phase = PH_IDLE;
    end
    if (clr) begin
      phase_nxt    = clr_phase;
      addr_cnt_nxt = 1'b0;
      match_nxt    = '0;
      name_pos_nxt = '0;
      cur_cmd_nxt  = '0;
      arg_cnt_nxt  = '0;
      watch_nxt    = RW_NONE;
    end
  end

  // Drain: status beat first, then one beat per stored argument byte
  always_comb begin
    drain_active_nxt = drain_active_r;
    stat_pend_nxt    = stat_pend_r;
    drain_idx_nxt    = drain_idx_r;
    drain_cnt_nxt    = drain_cnt_r;
    drain_status_nxt = drain_status_r;
    drain_cmd_nxt    = drain_cmd_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_status_nxt   = out_status_r;
    out_cmd_nxt      = out_cmd_r;
    out_char_nxt     = out_char_r;
    out_argv_nxt     = out_argv_r;
    out_last_nxt     = out_last_r;
    if (drain_active_r) begin
      if (load_ok) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = drain_status_r;
        out_cmd_nxt    = drain_cmd_r;
        if (stat_pend_r) begin
          out_char_nxt  = '0;
          out_argv_nxt  = 1'b0;
          out_last_nxt  = (drain_cnt_r == '0);
          stat_pend_nxt = 1'b0;
          if (drain_cnt_r == '0) begin
            drain_active_nxt = 1'b0;
          end
        end else begin
          out_char_nxt = rd_data_r;
          out_argv_nxt = 1'b1;
          out_last_nxt = (drain_idx_r + 1'b1 == drain_cnt_r);
          if (drain_idx_r + 1'b1 == drain_cnt_r) begin
            drain_active_nxt = 1'b0;
            drain_idx_nxt    = '0;
          end else begin
            drain_idx_nxt = drain_idx_r + 1'b1;
          end
        end
      end
    end else if (fin) begin
      drain_status_nxt = fin_status;
      drain_cmd_nxt    = cur_cmd_r;
      drain_cnt_nxt    = arg_cnt_r;
      drain_idx_nxt    = '0;
      if (load_ok) begin
        out_valid_nxt    = 1'b1;
        out_status_nxt   = fin_status;
        out_cmd_nxt      = cur_cmd_r;
        out_char_nxt     = '0;
        out_argv_nxt     = 1'b0;
        out_last_nxt     = (arg_cnt_r == '0);
        drain_active_nxt = (arg_cnt_r != '0);
        stat_pend_nxt    = 1'b0;
      end else begin
        drain_active_nxt = 1'b1;
        stat_pend_nxt    = 1'b1;
      end
    end
  end

  // Read ahead the byte the next argument beat needs
  assign rd_addr = drain_idx_nxt[AW-1:0];

  // Argument RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (st_we) begin
      arg_mem[arg_cnt_r[AW-1:0]] <= in_rx_byte;
    end
    rd_data_r <= arg_mem[rd_addr];
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      addr_cnt_r     <= 1'b0;
      match_r        <= '0;
      name_pos_r     <= '0;
      cur_cmd_r      <= '0;
      arg_cnt_r      <= '0;
      watch_r        <= RW_NONE;
      drain_active_r <= 1'b0;
      stat_pend_r    <= 1'b0;
      drain_idx_r    <= '0;
      out_valid_r    <= 1'b0;
      addr_first_r   <= acfp_pkg::ADDR_FIRST_RST;
      addr_second_r  <= acfp_pkg::ADDR_SECOND_RST;
    end else begin
      phase_r        <= phase_nxt;
      addr_cnt_r     <= addr_cnt_nxt;
      match_r        <= match_nxt;
      name_pos_r     <= name_pos_nxt;
      cur_cmd_r      <= cur_cmd_nxt;
      arg_cnt_r      <= arg_cnt_nxt;
      watch_r        <= watch_nxt;
      drain_active_r <= drain_active_nxt;
      stat_pend_r    <= stat_pend_nxt;
      drain_idx_r    <= drain_idx_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_valid && cfg_ready && cfg_index == acfp_pkg::REG_ADDR_FIRST) begin
        addr_first_r <= cfg_wdata;
      end
      if (cfg_valid && cfg_ready && cfg_index == acfp_pkg::REG_ADDR_SECOND) begin
        addr_second_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    drain_cnt_r    <= drain_cnt_nxt;
    drain_status_r <= drain_status_nxt;
    drain_cmd_r    <= drain_cmd_nxt;
    out_status_r   <= out_status_nxt;
    out_cmd_r      <= out_cmd_nxt;
    out_char_r     <= out_char_nxt;
    out_argv_r     <= out_argv_nxt;
    out_last_r     <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_command_id = out_cmd_r;
  assign out_arg_char   = out_char_r;
  assign out_arg_valid  = out_argv_r;
  assign out_last       = out_last_r;

  // Checks
  `ACFP_ASSERT_NEXT(a_fin_clears, in_fire && fin, phase_r == PH_IDLE && arg_cnt_r == '0, "frame end did not clear the frame")
  `ACFP_ASSERT_NOW(a_drain_idx, drain_active_r && !stat_pend_r, drain_idx_r < drain_cnt_r, "drain index ran past the argument count")
  `ACFP_ASSERT_NOW(a_arg_cnt, 1'b1, arg_cnt_r <= ARG_LIM, "argument count beyond store size")
  `ACFP_ASSERT_NOW(a_last_ends, drain_active_r && load_ok && out_last_nxt, !drain_active_nxt, "drain outlived its last beat")
  `ACFP_ASSERT_NOW(a_cmd_phase, cur_cmd_r != '0, phase_r == PH_NAME || phase_r == PH_ARG, "command held outside name or argument phase")

endmodule
